// ----- sv/rlm_pkg.sv -----
package rlm_pkg;

  // Fixed formats of the ports and the largest supported fraction
  localparam int FRAC_BITS_DEF = 30;
  localparam int MAX_FRAC = 30;
  localparam int CORDIC_ITERS = 30;
  localparam int IN_W = 32;
  localparam int DIFF_W = 33;
  localparam int ANG_W = 32;
  localparam int OUT_W = 34;
  localparam int THR_W = 31;
  localparam int RT_MAX_W = MAX_FRAC + 1;
  localparam logic [THR_W-1:0] THR_RST = 31'd1074;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Data that travels alongside the arithmetic through every cell
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic                     cneg;
    logic [RT_MAX_W-1:0]      ac;
    logic [RT_MAX_W-1:0]      s;
    logic                     szero;
    logic [ANG_W-1:0]         angle;
  } side_t;

  // atan(2^-i) in Q2.30, rounded down
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000007;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/rlm_ifs.sv -----
// Matrix channel
interface rlm_mat_if;
  logic valid;
  logic ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// Result channel
interface rlm_res_if;
  logic valid;
  logic ready;
  logic [31:0] angle;
  logic signed [33:0] rot_x;
  logic signed [33:0] rot_y;
  logic signed [33:0] rot_z;
  modport source(output valid, angle, rot_x, rot_y, rot_z, input ready);
  modport sink(input valid, angle, rot_x, rot_y, rot_z, output ready);
endinterface

// ----- sv/rlm_sqrt_cell.sv -----
// One result bit of the square root per cell
module rlm_sqrt_cell import rlm_pkg::*; #(
  parameter int R = 31,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  logic [2*R-1:0] rad_in,
  input  logic [R+1:0]   rem_in,
  input  logic [R-1:0]   q_in,
  input  side_t          sd_in,
  output logic           vout,
  output logic [2*R-1:0] rad_out,
  output logic [R+1:0]   rem_out,
  output logic [R-1:0]   q_out,
  output side_t          sd_out
);

  logic [R+1:0] rem_sh;
  logic [R+1:0] trial;
  logic         ge;

  // bring down the next two radicand bits and try root bit one
  assign rem_sh = {rem_in[R-1:0], rad_in[2*R-1-2*IDX -: 2]};
  assign trial  = {q_in, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= rad_in;
      rem_out <= ge ? rem_sh - trial : rem_sh;
      q_out   <= {q_in[R-2:0], ge};
      sd_out  <= sd_in;
    end
  end

endmodule

// ----- sv/rlm_cordic_cell.sv -----
// One vectoring rotation per cell
module rlm_cordic_cell import rlm_pkg::*; #(
  parameter int F = 30,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  logic signed [F+2:0] x_in,
  input  logic signed [F+2:0] y_in,
  input  logic signed [F+2:0] z_in,
  input  side_t               sd_in,
  output logic                vout,
  output logic signed [F+2:0] x_out,
  output logic signed [F+2:0] y_out,
  output logic signed [F+2:0] z_out,
  output side_t               sd_out
);

  localparam int CW = F + 3;
  localparam logic [31:0] TQ = atan_q30(IDX) >> (30 - F);

  logic signed [CW-1:0] t;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign t  = $signed(CW'(TQ));
  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in >= 0) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + t;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - t;
      end
      sd_out <= sd_in;
    end
  end

endmodule

// ----- sv/rlm_div_cell.sv -----
// One quotient bit of the restoring divider per cell
module rlm_div_cell import rlm_pkg::*; #(
  parameter int DW = 62,
  parameter int DVW = 32,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  logic [DW-1:0]  num_in,
  input  logic [DVW-1:0] dv_in,
  input  logic [DVW:0]   rem_in,
  input  logic [DW-1:0]  q_in,
  input  side_t          sd_in,
  output logic           vout,
  output logic [DW-1:0]  num_out,
  output logic [DVW-1:0] dv_out,
  output logic [DVW:0]   rem_out,
  output logic [DW-1:0]  q_out,
  output side_t          sd_out
);

  logic [DVW:0] r2;
  logic         ge;

  assign r2 = {rem_in[DVW-1:0], num_in[DW-1-IDX]};
  assign ge = r2 >= {1'b0, dv_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      dv_out  <= dv_in;
      rem_out <= ge ? r2 - {1'b0, dv_in} : r2;
      q_out   <= {q_in[DW-2:0], ge};
      sd_out  <= sd_in;
    end
  end

endmodule

// ----- sv/rotation_log_map.sv -----
// rotation_log_map: logarithm map of a 3x3 rotation matrix.
// The mat channel carries one matrix item (m00..m22, signed Q2.30); the
// res channel returns the angle (unsigned Q2.30, 0..pi) and the rotation
// vector rot_x/y/z (signed Q4.30, saturated) for each item, in order.
// cfg_we/cfg_data write small_angle_threshold; below or at it the
// antisymmetric differences are only halved. Write it only while idle.
// The datapath is one chain of cells: trace and clamp, squaring, the
// radicand, an FRAC_BITS+1 cell square root, 30 CORDIC cells, the angle
// stage, a 32+FRAC_BITS cell restoring divider for angle/(2 sin), two
// multiply stages and the output register. An item passes 2*FRAC_BITS + 70
// registers; one item is accepted every cycle while the receiver does not
// stall the chain.
// The whole chain moves as one: it advances whenever the output register
// is empty or being taken, so a stalled receiver holds every cell and
// drops mat.ready, and nothing is lost. Reset (rst, synchronous) clears
// all valid flags and sets the threshold to 1074.
module rotation_log_map import rlm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  rlm_mat_if.sink          mat,
  rlm_res_if.source        res,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int R   = F + 1;
  localparam int SQW = 2 * R;
  localparam int CW  = F + 3;
  localparam int DW  = ANG_W + F;
  localparam int DVW = R + 1;
  localparam int KL  = DW / 2;
  localparam int KH  = DW - KL;
  localparam int PW  = DW + DIFF_W;
  localparam int VW  = PW - F;
  localparam logic [ANG_W-1:0] PI_F = PI_Q30 >> (30 - F);
  localparam logic [31:0] HP_F = HALF_PI_Q30 >> (30 - F);
  localparam logic [VW-1:0] POS_LIM = VW'(64'h1_FFFF_FFFF);
  localparam logic [VW-1:0] NEG_LIM = VW'(64'h2_0000_0000);

  logic adv;
  logic [THR_W-1:0] thr;

  assign adv       = !res.valid || res.ready;
  assign mat.ready = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RST;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  // stage 0: trace, clamp, cos term and the differences
  logic signed [33:0] tr;
  logic signed [33:0] trc;
  logic signed [33:0] cc;
  logic signed [33:0] one34;
  logic [F:0]         ac_c;
  logic               v0;
  side_t              sd0_c;
  side_t              sd0;
  logic [F:0]         ac0;

  assign one34 = 34'sd1 <<< F;
  assign tr    = 34'(mat.m00) + 34'(mat.m11) + 34'(mat.m22);

  always_comb begin
    trc = tr;
    if (tr > 3 * one34) begin
      trc = 3 * one34;
    end
    if (tr < -one34) begin
      trc = -one34;
    end
    cc   = ((trc + one34) >>> 1) - one34;
    ac_c = cc[33] ? (F+1)'(-cc) : (F+1)'(cc);
  end

  // side data of the new item
  always_comb begin
    sd0_c      = '0;
    sd0_c.dx   = 33'(mat.m21) - 33'(mat.m12);
    sd0_c.dy   = 33'(mat.m02) - 33'(mat.m20);
    sd0_c.dz   = 33'(mat.m10) - 33'(mat.m01);
    sd0_c.cneg = cc[33];
    sd0_c.ac   = RT_MAX_W'(ac_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd0 <= sd0_c;
      ac0 <= ac_c;
    end
  end

  // stage 1: square of the cosine term; stage 2: radicand
  logic           v1;
  logic           v2;
  side_t          sd1;
  side_t          sd2;
  logic [SQW-1:0] sq1;
  logic [SQW-1:0] rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1  <= SQW'(ac0) * SQW'(ac0);
      sd1  <= sd0;
      rad2 <= (SQW'(1) << (2 * F)) - sq1;
      sd2  <= sd1;
    end
  end

  // square root chain
  logic           sq_v   [0:R];
  logic [SQW-1:0] sq_rad [0:R];
  logic [R+1:0]   sq_rem [0:R];
  logic [R-1:0]   sq_q   [0:R];
  side_t          sq_sd  [0:R];

  assign sq_v[0]   = v2;
  assign sq_rad[0] = rad2;
  assign sq_rem[0] = '0;
  assign sq_q[0]   = '0;
  assign sq_sd[0]  = sd2;

  for (genvar j = 0; j < R; j++) begin : g_sqrt
    rlm_sqrt_cell #(.R(R), .IDX(j)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .vin(sq_v[j]),
      .rad_in(sq_rad[j]), .rem_in(sq_rem[j]), .q_in(sq_q[j]), .sd_in(sq_sd[j]),
      .vout(sq_v[j+1]), .rad_out(sq_rad[j+1]), .rem_out(sq_rem[j+1]),
      .q_out(sq_q[j+1]), .sd_out(sq_sd[j+1])
    );
  end

  // CORDIC chain
  logic                 co_v  [0:CORDIC_ITERS];
  logic signed [CW-1:0] co_x  [0:CORDIC_ITERS];
  logic signed [CW-1:0] co_y  [0:CORDIC_ITERS];
  logic signed [CW-1:0] co_z  [0:CORDIC_ITERS];
  side_t                co_sd [0:CORDIC_ITERS];

  always_comb begin
    co_sd[0]       = sq_sd[R];
    co_sd[0].s     = RT_MAX_W'(sq_q[R]);
    co_sd[0].szero = sq_q[R] == '0;
  end

  assign co_v[0] = sq_v[R];
  assign co_x[0] = $signed(CW'(sq_sd[R].ac[F:0]));
  assign co_y[0] = $signed(CW'(sq_q[R]));
  assign co_z[0] = '0;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    rlm_cordic_cell #(.F(F), .IDX(i)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .vin(co_v[i]),
      .x_in(co_x[i]), .y_in(co_y[i]), .z_in(co_z[i]), .sd_in(co_sd[i]),
      .vout(co_v[i+1]), .x_out(co_x[i+1]), .y_out(co_y[i+1]),
      .z_out(co_z[i+1]), .sd_out(co_sd[i+1])
    );
  end

  // angle stage
  logic signed [CW-1:0] zl;
  logic signed [CW-1:0] zc;
  logic signed [CW-1:0] hp;
  logic [ANG_W-1:0]     ang_c;
  logic                 va;
  side_t                sda_c;
  side_t                sda;

  assign zl = co_z[CORDIC_ITERS];
  assign hp = $signed(CW'(HP_F));

  always_comb begin
    zc = zl;
    if (zl < 0) begin
      zc = '0;
    end
    if (zl > hp) begin
      zc = hp;
    end
    if (co_sd[CORDIC_ITERS].szero) begin
      ang_c = co_sd[CORDIC_ITERS].cneg ? PI_F : '0;
    end else if (co_sd[CORDIC_ITERS].cneg) begin
      ang_c = PI_F - ANG_W'(zc);
    end else begin
      ang_c = ANG_W'(zc);
    end
  end

  // side data with the angle filled in
  always_comb begin
    sda_c       = co_sd[CORDIC_ITERS];
    sda_c.angle = ang_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= co_v[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sda <= sda_c;
    end
  end

  // divider chain: k = (angle << F) / (2 s)
  logic           dv_v   [0:DW];
  logic [DW-1:0]  dv_num [0:DW];
  logic [DVW-1:0] dv_dv  [0:DW];
  logic [DVW:0]   dv_rem [0:DW];
  logic [DW-1:0]  dv_q   [0:DW];
  side_t          dv_sd  [0:DW];

  assign dv_v[0]   = va;
  assign dv_num[0] = {sda.angle, F'(0)};
  assign dv_dv[0]  = {sda.s[R-1:0], 1'b0};
  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;
  assign dv_sd[0]  = sda;

  for (genvar k = 0; k < DW; k++) begin : g_div
    rlm_div_cell #(.DW(DW), .DVW(DVW), .IDX(k)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .vin(dv_v[k]),
      .num_in(dv_num[k]), .dv_in(dv_dv[k]), .rem_in(dv_rem[k]), .q_in(dv_q[k]),
      .sd_in(dv_sd[k]),
      .vout(dv_v[k+1]), .num_out(dv_num[k+1]), .dv_out(dv_dv[k+1]),
      .rem_out(dv_rem[k+1]), .q_out(dv_q[k+1]), .sd_out(dv_sd[k+1])
    );
  end

  // multiply stages: partial products of k and each magnitude, then their sum
  logic signed [DIFF_W-1:0] dd [0:2];
  logic [DIFF_W-1:0]        mg [0:2];
  logic [KL+DIFF_W-1:0]     pl [0:2];
  logic [KH+DIFF_W-1:0]     ph [0:2];
  logic [VW-1:0]            pv [0:2];
  logic                     ng_m [0:2];
  logic                     ng_s [0:2];
  logic [DIFF_W-1:0]        mg_m [0:2];
  logic [DIFF_W-1:0]        mg_s [0:2];
  logic                     vm;
  logic                     vs;
  side_t                    sdm;
  side_t                    sds;

  assign dd[0] = dv_sd[DW].dx;
  assign dd[1] = dv_sd[DW].dy;
  assign dd[2] = dv_sd[DW].dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vs <= 1'b0;
    end else if (adv) begin
      vm <= dv_v[DW];
      vs <= vm;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_comp
    assign mg[g] = dd[g][DIFF_W-1] ? DIFF_W'(-dd[g]) : DIFF_W'(dd[g]);

    always_ff @(posedge clk) begin
      if (adv) begin
        pl[g]   <= (KL+DIFF_W)'(dv_q[DW][KL-1:0]) * (KL+DIFF_W)'(mg[g]);
        ph[g]   <= (KH+DIFF_W)'(dv_q[DW][DW-1:KL]) * (KH+DIFF_W)'(mg[g]);
        ng_m[g] <= dd[g][DIFF_W-1];
        mg_m[g] <= mg[g];
        // sum of the partial products, scaled back by F
        pv[g]   <= VW'(((PW'(ph[g]) << KL) + PW'(pl[g])) >> F);
        ng_s[g] <= ng_m[g];
        mg_s[g] <= mg_m[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdm <= dv_sd[DW];
      sds <= sdm;
    end
  end

  // final selection, saturation and output register
  logic              full;
  logic [VW-1:0]     mag_f [0:2];
  logic [OUT_W-1:0]  rv    [0:2];

  assign full = sds.angle > ANG_W'(thr);

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      if (!full) begin
        mag_f[n] = VW'(mg_s[n] >> 1);
      end else if (mg_s[n] == '0) begin
        mag_f[n] = '0;
      end else if (sds.szero) begin
        mag_f[n] = NEG_LIM + VW'(1);
      end else begin
        mag_f[n] = pv[n];
      end
      if (ng_s[n]) begin
        if (mag_f[n] > NEG_LIM) begin
          mag_f[n] = NEG_LIM;
        end
        rv[n] = OUT_W'(-mag_f[n]);
      end else begin
        if (mag_f[n] > POS_LIM) begin
          mag_f[n] = POS_LIM;
        end
        rv[n] = OUT_W'(mag_f[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.angle <= sds.angle;
      res.rot_x <= rv[0];
      res.rot_y <= rv[1];
      res.rot_z <= rv[2];
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rlm_pkg::*;

  typedef logic [8:0][31:0] mat_t;   // [0] = m00 ... [8] = m22

  typedef struct packed {
    logic [31:0]        angle;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [33:0] rz;
  } logv_t;

  localparam longint ONE_Q = 64'sd1 << 30;
  localparam longint unsigned PI_Q = 64'd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint unsigned SAT_MAG = 64'd8589934593;
  localparam logic [30:0] THR_LIST [4] = '{31'd0, 31'd1073741824, 31'd4096, 31'd1074};
  localparam int RAND_PER_PHASE = 350;
  localparam int DRAIN_CYCLES = 200;

  // atan(2^-i), Q2.30, rounded down
  localparam longint ATAN_TBL [30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
    'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
    'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
    'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
    'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
    'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [THR_W-1:0] cfg_data;

  rlm_mat_if mat ();
  rlm_res_if res ();

  rotation_log_map u_dut (
    .clk      (clk),
    .rst      (rst),
    .mat      (mat.sink),
    .res      (res.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  logv_t expected_q[$];
  logic [30:0] thr_cur;
  int idle_pct;
  int stall_pct;
  int errors = 0;

  always #2 clk = ~clk;

  // floor square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // one rotation-vector component from an antisymmetric difference
  function automatic logic signed [33:0] rot_comp(longint d, longint unsigned ang,
                                                  longint unsigned s, bit full);
    bit neg;
    longint unsigned mag;
    longint unsigned k;
    longint unsigned v;
    logic [127:0] prod;
    neg = d < 0;
    mag = neg ? -d : d;
    if (!full) begin
      v = mag >> 1;
    end else if (mag == 0) begin
      return '0;
    end else if (s == 0) begin
      v = SAT_MAG;
    end else begin
      k = (ang << 30) / (2 * s);
      prod = {64'd0, k} * {64'd0, mag};
      v = (prod[127:64] != 0) ? SAT_MAG : prod[93:30];
    end
    if (neg) begin
      if (v > 64'd8589934592) v = 64'd8589934592;
      return -$signed({1'b0, v[33:0]});
    end
    if (v > 64'd8589934591) v = 64'd8589934591;
    return v[33:0];
  endfunction

  // angle and rotation vector of one matrix
  function automatic logv_t log_map(mat_t m, logic [30:0] thr);
    longint a [9];
    longint tr, c, x, y, z, xs, ys;
    longint unsigned s, ang;
    bit full;
    logv_t r;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[i]));
    tr = a[0] + a[4] + a[8];
    if (tr > 3 * ONE_Q) tr = 3 * ONE_Q;
    if (tr < -ONE_Q) tr = -ONE_Q;
    c = ((tr + ONE_Q) >>> 1) - ONE_Q;
    s = int_sqrt(ONE_Q * ONE_Q - c * c);
    if (s == 0) begin
      ang = (c >= 0) ? 0 : PI_Q;
    end else begin
      x = (c < 0) ? -c : c;
      y = s;
      z = 0;
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ATAN_TBL[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_TBL[i];
        end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_Q) z = HALF_PI_Q;
      ang = (c >= 0) ? z : PI_Q - z;
      if (ang > PI_Q) ang = PI_Q;
    end
    full = ang > thr;
    r.angle = ang[31:0];
    r.rx = rot_comp(a[7] - a[5], ang, s, full);
    r.ry = rot_comp(a[2] - a[6], ang, s, full);
    r.rz = rot_comp(a[3] - a[1], ang, s, full);
    return r;
  endfunction

  function automatic mat_t mk(logic [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22);
    mat_t m;
    m = {a22, a21, a20, a12, a11, a10, a02, a01, a00};
    return m;
  endfunction

  function automatic logv_t lv(logic [31:0] ang, logic signed [33:0] x, y, z);
    logv_t r;
    r = '{ang, x, y, z};
    return r;
  endfunction

  function automatic logic [31:0] to_q(real v);
    return $rtoi(v * 1073741824.0) + int'($urandom_range(4)) - 2;
  endfunction

  // proper rotation, angle drawn from tiny, near-pi or the full range
  function automatic mat_t rand_rotation();
    real kx, ky, kz, n, th, c, s, t;
    int cat;
    kx = real'(int'($urandom_range(2000))) - 1000.0;
    ky = real'(int'($urandom_range(2000))) - 1000.0;
    kz = real'(int'($urandom_range(2000))) - 1000.0;
    n = $sqrt(kx * kx + ky * ky + kz * kz);
    if (n < 1.0) begin
      kx = 1.0; n = 1.0;
    end
    kx = kx / n; ky = ky / n; kz = kz / n;
    cat = $urandom_range(9);
    if (cat < 2)
      th = real'($urandom_range(1, 9)) * 10.0 ** (-real'($urandom_range(9, 3)));
    else if (cat == 2)
      th = 3.14159265358979 - 10.0 ** (-real'($urandom_range(9, 2)));
    else
      th = real'($urandom_range(1000000)) / 1000000.0 * 3.14159265358979;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    return mk(to_q(c + kx * kx * t), to_q(kx * ky * t - kz * s), to_q(kx * kz * t + ky * s),
              to_q(kx * ky * t + kz * s), to_q(c + ky * ky * t), to_q(ky * kz * t - kx * s),
              to_q(kx * kz * t - ky * s), to_q(ky * kz * t + kx * s), to_q(c + kz * kz * t));
  endfunction

  // present one item after an optional idle gap, wait for acceptance, store its expected result
  task automatic send_matrix(mat_t m, bit typed, logv_t exp_r);
    if ($urandom_range(99) < idle_pct) begin
      mat.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    mat.valid <= 1'b1;
    mat.m00 <= m[0]; mat.m01 <= m[1]; mat.m02 <= m[2];
    mat.m10 <= m[3]; mat.m11 <= m[4]; mat.m12 <= m[5];
    mat.m20 <= m[6]; mat.m21 <= m[7]; mat.m22 <= m[8];
    do @(posedge clk); while (!mat.ready);
    expected_q.push_back(typed ? exp_r : log_map(m, thr_cur));
  endtask

  // let the pipe empty completely
  task automatic drain();
    mat.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    logv_t e;
    if (!rst && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res.angle !== e.angle) begin
          $error("angle: expected %0d, got %0d", e.angle, res.angle);
          errors++;
        end
        if (res.rot_x !== e.rx) begin
          $error("rot_x: expected %0d, got %0d", e.rx, res.rot_x);
          errors++;
        end
        if (res.rot_y !== e.ry) begin
          $error("rot_y: expected %0d, got %0d", e.ry, res.rot_y);
          errors++;
        end
        if (res.rot_z !== e.rz) begin
          $error("rot_z: expected %0d, got %0d", e.rz, res.rot_z);
          errors++;
        end
      end
    end
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  // stimulus
  initial begin
    mat_t dir_m [$];
    bit dir_typed [$];
    logv_t dir_exp [$];
    mat_t m;
    int phase_idle;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    mat.valid = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
    idle_pct = 0;
    stall_pct = 0;
    phase_idle = 0;
    thr_cur = THR_RST;

    // directed rows; typed expectations only where obvious
    // identity: zero sine, angle zero
    dir_m.push_back(mk(32'h40000000, 0, 0, 0, 32'h40000000, 0, 0, 0, 32'h40000000));
    dir_typed.push_back(1); dir_exp.push_back(lv(0, 0, 0, 0));
    // half turn about x: zero sine, angle pi, zero differences
    dir_m.push_back(mk(32'h40000000, 0, 0, 0, 32'hC0000000, 0, 0, 0, 32'hC0000000));
    dir_typed.push_back(1); dir_exp.push_back(lv(PI_Q, 0, 0, 0));
    // angle pi with nonzero differences: saturate with sign
    dir_m.push_back(mk(32'h40000000, 0, 0, 0, 32'hC0000000, 0, 7, 5, 32'hC0000000));
    dir_typed.push_back(1);
    dir_exp.push_back(lv(PI_Q, 34'sd8589934591, -34'sd8589934592, 0));
    // trace clamped high, all fields at maximum
    dir_m.push_back({9{32'h7FFFFFFF}});
    dir_typed.push_back(1); dir_exp.push_back(lv(0, 0, 0, 0));
    // trace clamped low, all fields at minimum
    dir_m.push_back({9{32'h80000000}});
    dir_typed.push_back(1); dir_exp.push_back(lv(PI_Q, 0, 0, 0));
    // small angle, widest differences halved
    dir_m.push_back(mk(32'h40000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h40000000,
                       32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h40000000));
    dir_typed.push_back(1);
    dir_exp.push_back(lv(0, 34'sd2147483647, -34'sd2147483647, 34'sd2147483647));
    // predictor-checked rows
    dir_m.push_back(mk(0, 32'hC0000000, 0, 32'h40000000, 0, 0, 0, 0, 32'h40000000));
    dir_m.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_m.push_back(mk(32'h3FFFFFFF, 32'hFFFFFFF0, 0, 16, 32'h3FFFFFFF, 0, 0, 0,
                       32'h40000000));
    dir_m.push_back(mk(32'hC0000001, 0, 32'h00001000, 0, 32'h40000000, 0, 0, 0, 32'hC0000000));
    dir_m.push_back(mk(32'hC0000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'hC0000000,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h40000001));
    dir_m.push_back(mk(32'h20000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h20000000,
                       32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h20000000));
    dir_m.push_back(mk(32'h00000001, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hFFFFFFFF,
                       32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA, 32'h00000000));
    for (int i = 0; i < 7; i++) begin
      dir_typed.push_back(0); dir_exp.push_back('0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_m.size(); i++) send_matrix(dir_m[i], dir_typed[i], dir_exp[i]);

    // random phases, each with its own threshold, idling and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_we <= 1'b1;
      cfg_data <= (ph == 2) ? 31'($urandom_range(1 << 20)) : THR_LIST[ph];
      @(posedge clk);
      thr_cur = cfg_data;
      cfg_we <= 1'b0;
      case (ph)
        0: begin phase_idle = 0; stall_pct = 0; end
        1: begin phase_idle = 45; stall_pct = 0; end
        2: begin phase_idle = 0; stall_pct = 45; end
        default: begin phase_idle = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0, 1: m = {$urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
          2: begin
            // near identity or a half turn, small perturbations
            m = rand_rotation();
            m[0] = $urandom_range(1) ? 32'h40000000 - $urandom_range(64) : 32'hC0000000;
            m[4] = 32'h40000000 - $urandom_range(64);
            m[8] = $urandom_range(1) ? 32'h40000000 : 32'hC0000000 + $urandom_range(64);
          end
          default: m = rand_rotation();
        endcase
        // brief stretch without idling inside busy phases
        idle_pct = (n % 100 >= 50 && n % 100 < 60) ? 0 : phase_idle;
        send_matrix(m, 0, '0);
      end
    end

    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rlm_pkg.sv
sv/rlm_ifs.sv
sv/rlm_sqrt_cell.sv
sv/rlm_cordic_cell.sv
sv/rlm_div_cell.sv
sv/rotation_log_map.sv
tb/tb.sv
